### hw/rtl/cdrf_pkg.sv
package cdrf_pkg;

	// Storage and field sizes.
	localparam int MAX_ACTIVE = 256;
	localparam int COORD_BITS = 24;
	localparam int THR_W      = 9;
	localparam int DIST_W     = 20;
	localparam int PEAK_W     = 9;
	localparam int CNT_W      = $clog2(MAX_ACTIVE + 1);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = DIST_W;
	localparam int SUM_W      = ((COORD_BITS > DIST_W) ? COORD_BITS : DIST_W) + 1;
	localparam int IN_DATA_W  = ((3 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((2 * COORD_BITS + PEAK_W + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - 2 * COORD_BITS - PEAK_W;

	localparam logic [PEAK_W-1:0] PEAK_MAX     = '1;
	localparam logic [THR_W-1:0]  THRESH_RESET = THR_W'(3);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_THRESHOLD  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_DISTANCE = CFG_IDX_W'(1);

	// Word traveling down the cell chain. On a flush rd_end carries the contig length.
	typedef struct packed {
		logic                  vld;
		logic                  flush;
		logic [COORD_BITS-1:0] rd_start;
		logic [COORD_BITS-1:0] rd_end;
		logic [CNT_W-1:0]      depth;
		logic                  placed;
	} cdrf_tok_t;

endpackage

### hw/rtl/cdrf_cell.sv
module cdrf_cell
	import cdrf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  cdrf_tok_t tok_i,
	output cdrf_tok_t tok_o
);

	logic                  valid_q;
	logic [COORD_BITS-1:0] end_q;
	cdrf_tok_t             tok_q;

	logic      held;
	logic      valid_next;
	logic      store;
	cdrf_tok_t tok_next;

	// A held end survives only if it reaches the new read's start.
	assign held = valid_q && (end_q >= tok_i.rd_start);

	always_comb begin
		tok_next   = tok_i;
		valid_next = valid_q;
		store      = 1'b0;
		if (tok_i.vld) begin
			if (tok_i.flush) begin
				valid_next = 1'b0;
			end else if (held) begin
				tok_next.depth = tok_i.depth + CNT_W'(1);
			end else if (!tok_i.placed) begin
				// First free cell on the way takes the new end.
				store           = 1'b1;
				valid_next      = 1'b1;
				tok_next.placed = 1'b1;
				tok_next.depth  = tok_i.depth + CNT_W'(1);
			end else begin
				valid_next = 1'b0;
			end
		end
	end

	// Cell state and the word handed to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else if (adv) begin
			valid_q <= valid_next;
			tok_q   <= tok_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && store) begin
			end_q <= tok_i.rd_end;
		end
	end

	assign tok_o = tok_q;

endmodule

### hw/rtl/cdrf_region.sv
module cdrf_region
	import cdrf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cdrf_tok_t             tok,
	input  logic [THR_W-1:0]      depth_threshold,
	input  logic [DIST_W-1:0]     cluster_distance,
	input  logic                  out_ready,
	output logic                  adv,
	output logic                  out_valid,
	output logic [COORD_BITS-1:0] region_start,
	output logic [COORD_BITS-1:0] region_end,
	output logic [PEAK_W-1:0]     peak_depth,
	output logic                  overflow
);

	localparam int CMP_W = CNT_W + PEAK_W;

	logic                  in_region_q;
	logic [COORD_BITS-1:0] open_start_q;
	logic [COORD_BITS-1:0] last_end_q;
	logic [PEAK_W-1:0]     max_seen_q;
	logic                  overflowed_q;
	logic                  out_valid_q;
	logic [COORD_BITS-1:0] res_start_q;
	logic [COORD_BITS-1:0] res_end_q;
	logic [PEAK_W-1:0]     res_peak_q;
	logic                  res_ovf_q;

	logic                  take;
	logic                  emit;
	logic                  deep;
	logic                  far;
	logic                  ovf_now;
	logic [CMP_W-1:0]      depth_x;
	logic [PEAK_W-1:0]     depth_sat;
	logic [SUM_W-1:0]      reach;
	logic                  in_region_d;
	logic [COORD_BITS-1:0] open_start_d;
	logic [COORD_BITS-1:0] last_end_d;
	logic [PEAK_W-1:0]     max_seen_d;
	logic                  overflowed_d;
	logic [COORD_BITS-1:0] emit_end;
	logic                  emit_ovf;

	// The chain moves whenever the tail word can be consumed.
	assign adv  = !out_valid_q || out_ready || !tok.vld;
	assign take = adv && tok.vld;

	assign depth_x   = CMP_W'(tok.depth);
	assign depth_sat = (depth_x > CMP_W'(PEAK_MAX)) ? PEAK_MAX : depth_x[PEAK_W-1:0];
	assign deep      = depth_x > CMP_W'(depth_threshold);
	assign reach     = SUM_W'(last_end_q) + SUM_W'(cluster_distance);
	assign far       = SUM_W'(tok.rd_start) > reach;
	assign ovf_now   = overflowed_q || !tok.placed;

	// Region tracking for the word leaving the chain.
	always_comb begin
		in_region_d  = in_region_q;
		open_start_d = open_start_q;
		last_end_d   = last_end_q;
		max_seen_d   = max_seen_q;
		overflowed_d = overflowed_q;
		emit         = 1'b0;
		emit_end     = last_end_q;
		emit_ovf     = ovf_now;
		if (take) begin
			if (tok.flush) begin
				emit         = in_region_q;
				emit_end     = tok.rd_end;
				emit_ovf     = overflowed_q;
				in_region_d  = 1'b0;
				open_start_d = '0;
				max_seen_d   = '0;
				overflowed_d = 1'b0;
			end else begin
				overflowed_d = ovf_now;
				if (deep) begin
					if (!in_region_q) begin
						open_start_d = tok.rd_start;
						in_region_d  = 1'b1;
					end
					last_end_d = tok.rd_end;
					if (depth_x > CMP_W'(max_seen_q)) begin
						max_seen_d = depth_sat;
					end
				end else if (in_region_q && far) begin
					emit        = 1'b1;
					max_seen_d  = '0;
					in_region_d = 1'b0;
				end
			end
		end
	end

	// Region state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_region_q  <= 1'b0;
			open_start_q <= '0;
			max_seen_q   <= '0;
			overflowed_q <= 1'b0;
		end else begin
			in_region_q  <= in_region_d;
			open_start_q <= open_start_d;
			max_seen_q   <= max_seen_d;
			overflowed_q <= overflowed_d;
		end
	end

	always_ff @(posedge clk) begin
		last_end_q <= last_end_d;
	end

	// Output register holds a result word until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_start_q <= open_start_q;
			res_end_q   <= emit_end;
			res_peak_q  <= max_seen_q;
			res_ovf_q   <= emit_ovf;
		end
	end

	assign out_valid    = out_valid_q;
	assign region_start = res_start_q;
	assign region_end   = res_end_q;
	assign peak_depth   = res_peak_q;
	assign overflow     = res_ovf_q;

	// A result is never loaded over one the receiver has not taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || out_ready))
		else $error("result word overwritten while stalled");

	// Outside a region no peak is carried.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_region_q |-> (max_seen_q == '0))
		else $error("peak depth left over outside a region");

	// Overflow stays set until the contig ends.
	assert property (@(posedge clk) disable iff (!arst_n)
		(overflowed_q && !(take && tok.flush)) |=> overflowed_q)
		else $error("overflow flag lost within a contig");

	// Emitting a result always closes the region.
	assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> !in_region_q)
		else $error("region still open after its result");

endmodule

### hw/rtl/coverage_depth_region_flagger_unit.sv
// Coverage depth region flagger.
// Input words on s_axis carry one read interval (tuser = 0) or an end of contig
// (tuser = 1, contig length in the top field). Reads must arrive sorted by start.
// Result words on m_axis carry one closed high-coverage region each; most input
// words produce none. The cfg channel writes depth_threshold (index 0) and
// cluster_distance (index 1); it is always ready. The user must use it only
// while idle; the block itself does not enforce this. The active read ends
// live in a row of MAX_ACTIVE cells. Each word walks the row one cell per cycle,
// dropping stale ends, storing its own end in the first free cell and summing
// the depth, then enters the region tracker at the tail. Throughput is one input
// word per cycle while the row is not held; words follow each other down it.
// A result reaches m_axis through every cell register and the output register.
// When the receiver stalls with a result pending, the whole row holds once the
// next word reaches the tail, and s_axis_tready drops with it.
// Reset empties every cell and the tracker and sets depth_threshold to 3 and
// cluster_distance to 0; words are accepted from the first cycle after reset.
module coverage_depth_region_flagger_unit
	import cdrf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// read_start, read_end, contig_length (lowest bits first)
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// action
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// region_start, region_end, peak_depth, zero fill (lowest bits first)
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// overflow
	output logic                  m_axis_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [THR_W-1:0]      depth_threshold_q;
	logic [DIST_W-1:0]     cluster_distance_q;
	logic                  adv;
	cdrf_tok_t             head_tok;
	cdrf_tok_t             chain [0:MAX_ACTIVE];
	logic [COORD_BITS-1:0] region_start;
	logic [COORD_BITS-1:0] region_end;
	logic [PEAK_W-1:0]     peak_depth;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_threshold_q  <= THRESH_RESET;
			cluster_distance_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEPTH_THRESHOLD:  depth_threshold_q  <= cfg_data[THR_W-1:0];
				REG_CLUSTER_DISTANCE: cluster_distance_q <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// Input word enters the head of the row; a flush carries the contig length.
	assign s_axis_tready = adv;

	always_comb begin
		head_tok.vld      = s_axis_tvalid;
		head_tok.flush    = s_axis_tuser;
		head_tok.rd_start = s_axis_tdata[COORD_BITS-1:0];
		head_tok.rd_end   = s_axis_tuser ? s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]
		                                 : s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
		head_tok.depth    = '0;
		head_tok.placed   = 1'b0;
	end

	assign chain[0] = head_tok;

	// Row of active-end cells.
	for (genvar i = 0; i < MAX_ACTIVE; i++) begin : g_cell
		cdrf_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.tok_i (chain[i]),
			.tok_o (chain[i+1])
		);
	end

	// Region tracker and output register at the tail.
	cdrf_region u_region (
		.clk             (clk),
		.arst_n          (arst_n),
		.tok             (chain[MAX_ACTIVE]),
		.depth_threshold (depth_threshold_q),
		.cluster_distance(cluster_distance_q),
		.out_ready       (m_axis_tready),
		.adv             (adv),
		.out_valid       (m_axis_tvalid),
		.region_start    (region_start),
		.region_end      (region_end),
		.peak_depth      (peak_depth),
		.overflow        (m_axis_tuser)
	);

	assign m_axis_tdata = {OUT_PAD_W'(0), peak_depth, region_end, region_start};

endmodule
